/* rtl/lsbb_pkg.sv */
package lsbb_pkg;

  localparam int TIME_W     = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;
  localparam int RAMP_W     = 7;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_OVR_RED    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_OVR_GREEN  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_OVR_BLUE   = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_OVR_ENABLE = CFG_IDX_W'(4);

  localparam logic [7:0] BRIGHT_RESET = 8'd255;
  localparam logic [7:0] PHASE_WRAP   = 8'd150;
  localparam logic [7:0] BREATH_HALF  = 8'd75;
  localparam logic [7:0] GREY_LEVEL   = 8'd64;
  localparam logic [7:0] BLUE_SOLID   = 8'd64;

  localparam logic [TIME_W-1:0] OFF_MS    = TIME_W'(200);
  localparam logic [TIME_W-1:0] ON_MS     = TIME_W'(100);
  localparam logic [TIME_W-1:0] UPDATE_MS = TIME_W'(20);

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_ON   = 2'd1,
    MODE_OFF  = 2'd2
  } blink_mode_t;

  typedef enum logic [2:0] {
    SRC_BLACK,
    SRC_GREY,
    SRC_OVR,
    SRC_OVR_BREATH,
    SRC_BLUE_BREATH,
    SRC_BLUE_SOLID
  } color_src_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_PICK,
    ST_SCALE
  } ctrl_state_t;

  typedef struct packed {
    logic eval;
    logic mul;
    logic pick;
    logic scale;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_stat_t;

  // 4 + ramp^2 * 251 / 5625 for ramp 0..75
  localparam logic [7:0] EASE_LUT [76] = '{
    8'd4,   8'd4,   8'd4,   8'd4,   8'd4,   8'd5,   8'd5,   8'd6,   8'd6,   8'd7,
    8'd8,   8'd9,   8'd10,  8'd11,  8'd12,  8'd14,  8'd15,  8'd16,  8'd18,  8'd20,
    8'd21,  8'd23,  8'd25,  8'd27,  8'd29,  8'd31,  8'd34,  8'd36,  8'd38,  8'd41,
    8'd44,  8'd46,  8'd49,  8'd52,  8'd55,  8'd58,  8'd61,  8'd65,  8'd68,  8'd71,
    8'd75,  8'd79,  8'd82,  8'd86,  8'd90,  8'd94,  8'd98,  8'd102, 8'd106, 8'd111,
    8'd115, 8'd120, 8'd124, 8'd129, 8'd134, 8'd138, 8'd143, 8'd148, 8'd154, 8'd159,
    8'd164, 8'd170, 8'd175, 8'd181, 8'd186, 8'd192, 8'd198, 8'd204, 8'd210, 8'd216,
    8'd222, 8'd228, 8'd235, 8'd241, 8'd248, 8'd255
  };

  // exact floor(p / 255) for any 16-bit p up to 255 * 255
  function automatic logic [7:0] div255(input logic [15:0] p);
    logic [16:0] s;
    s = {1'b0, p} + {9'd0, p[15:8]} + 17'd1;
    return s[15:8];
  endfunction

  // (c * (b + 1)) >> 8
  function automatic logic [7:0] scale_ch(input logic [7:0] c, input logic [7:0] b);
    logic [16:0] prod;
    prod = {9'd0, c} * ({9'd0, b} + 17'd1);
    return prod[15:8];
  endfunction

endpackage

/* rtl/lsbb_in_if.sv */
interface lsbb_in_if;
  logic                        valid;
  logic                        ready;
  logic                        command;
  logic [lsbb_pkg::TIME_W-1:0] now_ms;
  logic                        connected;
  logic [7:0]                  profile_num;

  modport source (output valid, command, now_ms, connected, profile_num, input ready);
  modport sink (input valid, command, now_ms, connected, profile_num, output ready);
endinterface

/* rtl/lsbb_out_if.sv */
interface lsbb_out_if;
  logic       valid;
  logic       ready;
  logic       send_pixel;
  logic [7:0] green_out;
  logic [7:0] red_out;
  logic [7:0] blue_out;
  logic       indicating;

  modport source (output valid, send_pixel, green_out, red_out, blue_out, indicating,
                  input ready);
  modport sink (input valid, send_pixel, green_out, red_out, blue_out, indicating,
                output ready);
endinterface

/* rtl/led_status_blink_breathe.sv */
// Status LED color controller.
// in_ch carries one step per transfer: command (task or indicate), now_ms,
// connected and profile_num. out_ch returns exactly one result per step:
// send_pixel, the brightness-scaled green/red/blue bytes (zero when nothing
// is sent) and the indicating flag.
// Registers are written through cfg_we/cfg_index/cfg_data: 0 brightness,
// 1..3 override red/green/blue, 4 override enable. The user must write them
// only while no step is in flight; the block itself does not enforce it.
// One step is in flight at a time and in_ready comes back in the cycle after
// the result is loaded into the output register, so a new step is not taken
// before the last one is through; the sequence is eval, color multiply,
// select/compare, brightness multiply.
// The output register sits apart from the sequencer: a waiting result does
// not stop the next step from being accepted and worked on; that step only
// holds in its last cycle until the waiting result has been taken.
// Synchronous reset: no blink sequence, breathing phase and timestamps zero,
// nothing cached, brightness 255, override color off; no pending result.
module led_status_blink_breathe (
  input  logic                            clk,
  input  logic                            rst_n,
  lsbb_in_if.sink                         in_ch,
  lsbb_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [lsbb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lsbb_pkg::CFG_DATA_W-1:0] cfg_data
);

  lsbb_pkg::dp_cmd_t  cmd;
  lsbb_pkg::dp_stat_t stat;
  logic               in_ready;

  assign in_ch.ready = in_ready;

  lsbb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lsbb_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_command     (in_ch.command),
    .in_now_ms      (in_ch.now_ms),
    .in_connected   (in_ch.connected),
    .in_profile_num (in_ch.profile_num),
    .cmd            (cmd),
    .stat           (stat),
    .out_ch         (out_ch)
  );

endmodule

/* rtl/lsbb_ctrl.sv */
module lsbb_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  lsbb_pkg::dp_stat_t stat,
  output lsbb_pkg::dp_cmd_t  cmd
);

  lsbb_pkg::ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lsbb_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lsbb_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = lsbb_pkg::ST_MUL;
      end
      lsbb_pkg::ST_MUL:  state_nxt = lsbb_pkg::ST_PICK;
      lsbb_pkg::ST_PICK: state_nxt = lsbb_pkg::ST_SCALE;
      lsbb_pkg::ST_SCALE: begin
        // hold until the output register is free
        if (stat.out_free) state_nxt = lsbb_pkg::ST_IDLE;
      end
      default: state_nxt = lsbb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    cmd       = '0;
    unique case (state_r)
      lsbb_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.eval = in_valid;
      end
      lsbb_pkg::ST_MUL:   cmd.mul = 1'b1;
      lsbb_pkg::ST_PICK:  cmd.pick = 1'b1;
      lsbb_pkg::ST_SCALE: cmd.scale = stat.out_free;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

/* rtl/lsbb_dp.sv */
module lsbb_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [lsbb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lsbb_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_command,
  input  logic [lsbb_pkg::TIME_W-1:0]     in_now_ms,
  input  logic                            in_connected,
  input  logic [7:0]                      in_profile_num,
  input  lsbb_pkg::dp_cmd_t               cmd,
  output lsbb_pkg::dp_stat_t              stat,
  lsbb_out_if.source                      out_ch
);

  // configuration
  logic [7:0] bright_r;
  logic [7:0] ovr_red_r, ovr_green_r, ovr_blue_r;
  logic       ovr_en_r;

  // block state
  lsbb_pkg::blink_mode_t       mode_r, mode_nxt;
  logic [7:0]                  blinks_r, blinks_nxt;
  logic [lsbb_pkg::TIME_W-1:0] phase_start_r, phase_start_nxt;
  logic [lsbb_pkg::TIME_W-1:0] last_upd_r, last_upd_nxt;
  logic [7:0]                  breath_r, breath_nxt;
  logic [23:0]                 cache_color_r;
  logic                        cache_valid_r;

  // per-item working registers
  logic                   req_r, req_nxt;
  lsbb_pkg::color_src_t   src_r, src_nxt;
  logic                   indic_r;
  logic [7:0]             ease_r;
  logic [15:0]            prod_red_r, prod_green_r, prod_blue_r;
  logic [7:0]             col_red_r, col_green_r, col_blue_r;
  logic                   send_r;

  // output register
  logic       out_valid_r;
  logic       out_send_r;
  logic [7:0] out_green_r, out_red_r, out_blue_r;
  logic       out_indic_r;

  logic [lsbb_pkg::TIME_W-1:0] elapsed, since_upd;
  logic [7:0]                  breath_inc, breath_step, ramp_full;
  logic [lsbb_pkg::RAMP_W-1:0] ramp;
  logic [7:0]                  blinks_dec;

  logic [7:0]  sel_red, sel_green, sel_blue;
  logic [23:0] sel_packed;
  logic        cache_hit, send_nxt;

  // ---------------- step evaluation, straight off the input transfer
  assign elapsed    = in_now_ms - phase_start_r;
  assign since_upd  = in_now_ms - last_upd_r;
  assign breath_inc = breath_r + 8'd1;
  assign breath_step = (breath_inc >= lsbb_pkg::PHASE_WRAP) ? 8'd0 : breath_inc;
  assign ramp_full  = (breath_step < lsbb_pkg::BREATH_HALF) ? breath_step
                                                            : lsbb_pkg::PHASE_WRAP - breath_step;
  assign ramp       = ramp_full[lsbb_pkg::RAMP_W-1:0];
  assign blinks_dec = blinks_r - 8'd1;

  always_comb begin
    mode_nxt        = mode_r;
    blinks_nxt      = blinks_r;
    phase_start_nxt = phase_start_r;
    last_upd_nxt    = last_upd_r;
    breath_nxt      = breath_r;
    req_nxt         = 1'b0;
    src_nxt         = lsbb_pkg::SRC_BLACK;
    if (in_command) begin
      // indicate: only starts a sequence from idle
      if (mode_r == lsbb_pkg::MODE_IDLE) begin
        blinks_nxt      = in_profile_num + 8'd1;
        mode_nxt        = lsbb_pkg::MODE_OFF;
        phase_start_nxt = in_now_ms;
      end
    end else begin
      unique case (mode_r)
        lsbb_pkg::MODE_OFF: begin
          req_nxt = 1'b1;
          src_nxt = lsbb_pkg::SRC_BLACK;
          if (elapsed >= lsbb_pkg::OFF_MS) begin
            blinks_nxt      = blinks_dec;
            mode_nxt        = (blinks_dec != 8'd0) ? lsbb_pkg::MODE_ON : lsbb_pkg::MODE_IDLE;
            phase_start_nxt = in_now_ms;
          end
        end
        lsbb_pkg::MODE_ON: begin
          req_nxt = 1'b1;
          src_nxt = ovr_en_r ? lsbb_pkg::SRC_OVR : lsbb_pkg::SRC_GREY;
          if (elapsed >= lsbb_pkg::ON_MS) begin
            mode_nxt        = lsbb_pkg::MODE_OFF;
            phase_start_nxt = in_now_ms;
          end
        end
        lsbb_pkg::MODE_IDLE: begin
          if (since_upd >= lsbb_pkg::UPDATE_MS) begin
            last_upd_nxt = in_now_ms;
            breath_nxt   = breath_step;
            req_nxt      = 1'b1;
            priority if (ovr_en_r && !in_connected) src_nxt = lsbb_pkg::SRC_OVR_BREATH;
            else if (ovr_en_r)                      src_nxt = lsbb_pkg::SRC_OVR;
            else if (!in_connected)                 src_nxt = lsbb_pkg::SRC_BLUE_BREATH;
            else                                    src_nxt = lsbb_pkg::SRC_BLUE_SOLID;
          end
        end
        default: mode_nxt = lsbb_pkg::MODE_IDLE;
      endcase
    end
  end

  // ---------------- color selection and repeat suppression
  always_comb begin
    sel_red   = 8'd0;
    sel_green = 8'd0;
    sel_blue  = 8'd0;
    unique case (src_r)
      lsbb_pkg::SRC_BLACK: begin
        sel_red = 8'd0;
      end
      lsbb_pkg::SRC_GREY: begin
        sel_red   = lsbb_pkg::GREY_LEVEL;
        sel_green = lsbb_pkg::GREY_LEVEL;
        sel_blue  = lsbb_pkg::GREY_LEVEL;
      end
      lsbb_pkg::SRC_OVR: begin
        sel_red   = ovr_red_r;
        sel_green = ovr_green_r;
        sel_blue  = ovr_blue_r;
      end
      lsbb_pkg::SRC_OVR_BREATH: begin
        sel_red   = lsbb_pkg::div255(prod_red_r);
        sel_green = lsbb_pkg::div255(prod_green_r);
        sel_blue  = lsbb_pkg::div255(prod_blue_r);
      end
      lsbb_pkg::SRC_BLUE_BREATH: sel_blue = ease_r;
      lsbb_pkg::SRC_BLUE_SOLID:  sel_blue = lsbb_pkg::BLUE_SOLID;
      default: sel_red = 8'd0;
    endcase
  end

  assign sel_packed = {sel_red, sel_green, sel_blue};
  assign cache_hit  = cache_valid_r && (cache_color_r == sel_packed);
  assign send_nxt   = req_r && !cache_hit;

  // ---------------- control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bright_r      <= lsbb_pkg::BRIGHT_RESET;
      ovr_red_r     <= 8'd0;
      ovr_green_r   <= 8'd0;
      ovr_blue_r    <= 8'd0;
      ovr_en_r      <= 1'b0;
      mode_r        <= lsbb_pkg::MODE_IDLE;
      blinks_r      <= 8'd0;
      phase_start_r <= '0;
      last_upd_r    <= '0;
      breath_r      <= 8'd0;
      cache_color_r <= 24'd0;
      cache_valid_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          lsbb_pkg::REG_BRIGHTNESS: begin
            // a new brightness makes the cached color stale
            if (cfg_data[7:0] != bright_r) begin
              bright_r      <= cfg_data[7:0];
              cache_valid_r <= 1'b0;
            end
          end
          lsbb_pkg::REG_OVR_RED:    ovr_red_r   <= cfg_data[7:0];
          lsbb_pkg::REG_OVR_GREEN:  ovr_green_r <= cfg_data[7:0];
          lsbb_pkg::REG_OVR_BLUE:   ovr_blue_r  <= cfg_data[7:0];
          lsbb_pkg::REG_OVR_ENABLE: ovr_en_r    <= cfg_data[0];
          default: ovr_en_r <= ovr_en_r;
        endcase
      end
      if (cmd.eval) begin
        mode_r        <= mode_nxt;
        blinks_r      <= blinks_nxt;
        phase_start_r <= phase_start_nxt;
        last_upd_r    <= last_upd_nxt;
        breath_r      <= breath_nxt;
      end
      if (cmd.pick && send_nxt) begin
        cache_color_r <= sel_packed;
        cache_valid_r <= 1'b1;
      end
      if (cmd.scale) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---------------- payload registers
  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      req_r   <= req_nxt;
      src_r   <= src_nxt;
      indic_r <= (mode_nxt != lsbb_pkg::MODE_IDLE);
      ease_r  <= lsbb_pkg::EASE_LUT[ramp];
    end
    if (cmd.mul) begin
      prod_red_r   <= {8'd0, ovr_red_r} * {8'd0, ease_r};
      prod_green_r <= {8'd0, ovr_green_r} * {8'd0, ease_r};
      prod_blue_r  <= {8'd0, ovr_blue_r} * {8'd0, ease_r};
    end
    if (cmd.pick) begin
      col_red_r   <= sel_red;
      col_green_r <= sel_green;
      col_blue_r  <= sel_blue;
      send_r      <= send_nxt;
    end
    if (cmd.scale) begin
      out_send_r  <= send_r;
      out_green_r <= send_r ? lsbb_pkg::scale_ch(col_green_r, bright_r) : 8'd0;
      out_red_r   <= send_r ? lsbb_pkg::scale_ch(col_red_r, bright_r) : 8'd0;
      out_blue_r  <= send_r ? lsbb_pkg::scale_ch(col_blue_r, bright_r) : 8'd0;
      out_indic_r <= indic_r;
    end
  end

  assign stat.out_free = !out_valid_r || out_ch.ready;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.send_pixel = out_send_r;
  assign out_ch.green_out  = out_green_r;
  assign out_ch.red_out    = out_red_r;
  assign out_ch.blue_out   = out_blue_r;
  assign out_ch.indicating = out_indic_r;

endmodule

/* rtl/lsbb_checker.sv */
module lsbb_assertions (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_send,
  input logic [7:0] out_green,
  input logic [7:0] out_red,
  input logic [7:0] out_blue,
  input logic       out_indic
);

  // stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable({out_send, out_green, out_red, out_blue, out_indic}))
    else $error("result changed while stalled");

  a_no_send_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_send |-> out_green == 8'd0 && out_red == 8'd0 && out_blue == 8'd0)
    else $error("color bytes set without a send");

  // one step in flight: in_ready stays low after a transfer while the step is worked on
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready ##1 !in_ready ##1 !in_ready)
    else $error("step accepted while another is in flight");

  // an empty output register is loaded only after a transfer whose step has been worked on
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 4))
    else $error("result appeared without a matching step");

endmodule

bind led_status_blink_breathe lsbb_assertions u_lsbb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_send  (out_ch.send_pixel),
  .out_green (out_ch.green_out),
  .out_red   (out_ch.red_out),
  .out_blue  (out_ch.blue_out),
  .out_indic (out_ch.indicating)
);
